// File: hw/rtl/dtt_pkg.sv
// Shared widths, codes and types for the debounced two/four-stroke trigger.
`default_nettype none
package dtt_pkg;

    localparam int LIMIT_W    = 10;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam int TDATA_W    = 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd500;
    localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 10'd1;

    localparam logic [MODE_W-1:0] MODE_TWO_STROKE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FOUR_STROKE = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MODE   = 1'd1;

    typedef struct packed {
        logic [LIMIT_W-1:0] debounce_limit;
        logic [MODE_W-1:0]  trigger_mode;
    } cfg_t;

    typedef struct packed {
        logic level;
        logic level_next;
    } deb_status_t;

    typedef struct packed {
        logic run;
        logic run_next;
    } trk_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/dtt_debounce.sv
// Integrating debouncer: up/down count with clamp and debounced level.
`default_nettype none
module dtt_debounce (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                pin,
    input  wire dtt_pkg::cfg_t       cfg,
    output dtt_pkg::deb_status_t     status
);

    logic [dtt_pkg::LIMIT_W-1:0] integ_reg;
    logic [dtt_pkg::LIMIT_W-1:0] integ_next;
    logic                        level_reg;
    logic                        level_next;
    logic [dtt_pkg::LIMIT_W-1:0] lim_eff;
    logic [dtt_pkg::LIMIT_W-1:0] inc;

    always_comb begin
        lim_eff = (cfg.debounce_limit == '0) ? dtt_pkg::LIMIT_MIN : cfg.debounce_limit;
        inc     = integ_reg + dtt_pkg::LIMIT_W'(1);
        integ_next = integ_reg;
        level_next = level_reg;
        if (pin) begin
            if (inc >= lim_eff) begin
                integ_next = lim_eff - dtt_pkg::LIMIT_W'(1);
                level_next = 1'b1;
            end else begin
                integ_next = inc;
            end
        end else if (integ_reg != '0) begin
            integ_next = integ_reg - dtt_pkg::LIMIT_W'(1);
        end else begin
            level_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
            level_reg <= 1'b0;
        end else if (en) begin
            integ_reg <= integ_next;
            level_reg <= level_next;
        end
    end

    assign status.level      = level_reg;
    assign status.level_next = level_next;

endmodule
`default_nettype wire

// File: hw/rtl/dtt_tracker.sv
// Press/release phase tracker and two-stroke / four-stroke start latch.
`default_nettype none
module dtt_tracker (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                level,
    input  wire dtt_pkg::cfg_t       cfg,
    output dtt_pkg::trk_status_t     status
);

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESS1   = 2'd1,
        PH_RELEASE1 = 2'd2,
        PH_PRESS2   = 2'd3
    } phase_t;

    phase_t phase_reg, phase_next;
    phase_t event_reg, event_next;
    logic   run_reg, run_next;

    always_comb begin
        phase_next = phase_reg;
        event_next = event_reg;
        run_next   = run_reg;
        if (level) begin
            if (phase_reg == PH_IDLE) begin
                phase_next = PH_PRESS1;
                event_next = PH_PRESS1;
            end else if (phase_reg == PH_RELEASE1) begin
                phase_next = PH_PRESS2;
                event_next = PH_PRESS2;
            end
        end else begin
            if (phase_reg == PH_PRESS1) begin
                phase_next = PH_RELEASE1;
                event_next = PH_RELEASE1;
            end else if (phase_reg == PH_PRESS2) begin
                phase_next = PH_IDLE;
                event_next = PH_IDLE;
            end
        end
        if (cfg.trigger_mode == dtt_pkg::MODE_FOUR_STROKE) begin
            if (event_next == PH_RELEASE1) begin
                run_next = 1'b1;
            end else if (event_next == PH_IDLE) begin
                run_next = 1'b0;
            end
        end else begin
            if (event_next == PH_PRESS1) begin
                phase_next = PH_PRESS2;
                run_next   = 1'b1;
            end else if (event_next == PH_IDLE) begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            event_reg <= PH_IDLE;
            run_reg   <= 1'b0;
        end else if (en) begin
            phase_reg <= phase_next;
            event_reg <= event_next;
            run_reg   <= run_next;
        end
    end

    assign status.run      = run_reg;
    assign status.run_next = run_next;

endmodule
`default_nettype wire

// File: hw/rtl/debounced_trigger_two_four_stroke.sv
// Top level: input register, debouncer, tracker and result register.
//
// Usage: each s_ transfer carries one sample tick of the raw trigger pin in
// s_tdata[0]. Every tick yields exactly one m_ transfer with the start output
// in m_tdata[0] and the debounced trigger level in m_tdata[1].
// Path: an accepted sample is held in the input register; when it advances,
// the debouncer, tracker and result register load together and m_tvalid rises.
// Throughput: one tick per cycle while m_tready stays high; the debouncer and
// tracker update their state in the same cycle that loads the result register.
// Stall: when m_tready is low the result is held and the input register
// keeps one more sample, after which s_tready drops until the result moves.
// Configuration: cfg_wr_en writes register cfg_index (0 debounce limit,
// 1 trigger mode) from cfg_wdata; write only while no tick is in flight.
// Reset (aresetn low, synchronous): both channels empty, count, level,
// phase and latch cleared, debounce limit 500, two-stroke mode.
`default_nettype none
module debounced_trigger_two_four_stroke (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [dtt_pkg::TDATA_W-1:0]      s_tdata,   // [0] pin_level
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [dtt_pkg::TDATA_W-1:0]           m_tdata,   // [0] start_res, [1] pressed
    input  wire logic                             cfg_wr_en,
    input  wire logic [dtt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dtt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    dtt_pkg::cfg_t        cfg_reg;
    dtt_pkg::deb_status_t deb_st;
    dtt_pkg::trk_status_t trk_st;

    logic in_valid_reg;
    logic in_pin_reg;
    logic out_valid_reg;
    logic out_start_reg;
    logic out_pressed_reg;
    logic advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_limit <= dtt_pkg::LIMIT_RESET;
            cfg_reg.trigger_mode   <= dtt_pkg::MODE_TWO_STROKE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dtt_pkg::CFG_DEBOUNCE_LIMIT:
                    cfg_reg.debounce_limit <= cfg_wdata[dtt_pkg::LIMIT_W-1:0];
                dtt_pkg::CFG_TRIGGER_MODE:
                    cfg_reg.trigger_mode <= cfg_wdata[dtt_pkg::MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_pin_reg <= s_tdata[0];
        end
    end

    dtt_debounce u_debounce (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .pin     (in_pin_reg),
        .cfg     (cfg_reg),
        .status  (deb_st)
    );

    dtt_tracker u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .level   (deb_st.level_next),
        .cfg     (cfg_reg),
        .status  (trk_st)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_start_reg   <= trk_st.run_next;
            out_pressed_reg <= deb_st.level_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(dtt_pkg::TDATA_W-2){1'b0}}, out_pressed_reg, out_start_reg};

`ifndef NO_ASSERTIONS
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input register empty but s_tready low");

    a_pressed_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_pressed_reg == deb_st.level))
        else $error("pending result level differs from debouncer state");

    a_start_tracks_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_start_reg == trk_st.run))
        else $error("pending result start differs from latch state");

    a_stall_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> $stable(deb_st.level) && $stable(trk_st.run))
        else $error("state advanced while result stalled");
`endif

endmodule
`default_nettype wire

// File: bench/debounced_trigger_two_four_stroke_tb.sv
// Self-checking bench for the debounced two/four-stroke trigger with a per-sample predictor.
`default_nettype none
module debounced_trigger_two_four_stroke_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [dtt_pkg::MODE_W-1:0] MODE_TWO_STROKE_ALT2 = 2'd2;
    localparam logic [dtt_pkg::MODE_W-1:0] MODE_TWO_STROKE_ALT3 = 2'd3;
    localparam int QUIET_LIMIT = 1000;
    localparam int ERR_PRINT_MAX = 25;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIRST_PRESS,
        PH_FIRST_RELEASE,
        PH_SECOND_PRESS
    } stroke_phase_t;

    typedef struct {
        logic start_res;
        logic pressed;
    } trig_out_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [dtt_pkg::TDATA_W-1:0]    s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [dtt_pkg::TDATA_W-1:0]    m_tdata;
    logic                           cfg_wr_en = 1'b0;
    logic [dtt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [dtt_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    debounced_trigger_two_four_stroke u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state and configuration copy
    logic [dtt_pkg::LIMIT_W-1:0] cfg_limit = dtt_pkg::LIMIT_RESET;
    logic [dtt_pkg::MODE_W-1:0]  cfg_mode = dtt_pkg::MODE_TWO_STROKE;
    logic [dtt_pkg::LIMIT_W-1:0] integ = '0;
    logic                        level = 1'b0;
    stroke_phase_t               stroke_ph = PH_IDLE;
    stroke_phase_t               last_ev = PH_IDLE;
    logic                        run_latch = 1'b0;

    bit        pin_queue[$];
    trig_out_t pending_outs[$];
    int        err_count = 0;
    int        out_count = 0;
    bit        gaps_on = 1'b1;
    int        gap_left = 0;
    int        stall_left = 0;
    int        quiet_cycles = 0;

    task automatic flag_error(input string msg);
        if (err_count < ERR_PRINT_MAX) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        err_count++;
    endtask

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    task automatic advance_trigger(input logic pin);
        logic [dtt_pkg::LIMIT_W-1:0] lim;
        trig_out_t                   out;
        lim = (cfg_limit == '0) ? dtt_pkg::LIMIT_MIN : cfg_limit;
        if (pin) begin
            integ = integ + 1'b1;
            if (integ >= lim) begin
                integ = lim - 1'b1;
                level = 1'b1;
            end
        end else if (integ != '0) begin
            integ = integ - 1'b1;
        end else begin
            level = 1'b0;
        end

        if (level) begin
            if (stroke_ph == PH_IDLE) begin
                stroke_ph = PH_FIRST_PRESS;
                last_ev = PH_FIRST_PRESS;
            end else if (stroke_ph == PH_FIRST_RELEASE) begin
                stroke_ph = PH_SECOND_PRESS;
                last_ev = PH_SECOND_PRESS;
            end
        end else begin
            if (stroke_ph == PH_FIRST_PRESS) begin
                stroke_ph = PH_FIRST_RELEASE;
                last_ev = PH_FIRST_RELEASE;
            end else if (stroke_ph == PH_SECOND_PRESS) begin
                stroke_ph = PH_IDLE;
                last_ev = PH_IDLE;
            end
        end

        if (cfg_mode == dtt_pkg::MODE_FOUR_STROKE) begin
            if (last_ev == PH_FIRST_RELEASE) begin
                run_latch = 1'b1;
            end else if (last_ev == PH_IDLE) begin
                run_latch = 1'b0;
            end
        end else begin
            if (last_ev == PH_FIRST_PRESS) begin
                stroke_ph = PH_SECOND_PRESS;
                run_latch = 1'b1;
            end else if (last_ev == PH_IDLE) begin
                run_latch = 1'b0;
            end
        end

        out.start_res = run_latch;
        out.pressed = level;
        pending_outs.push_back(out);
    endtask

    task automatic check_result(input logic start_got, input logic pressed_got);
        trig_out_t want;
        if (pending_outs.size() == 0) begin
            flag_error($sformatf("result %0d arrived with nothing pending", out_count));
        end else begin
            want = pending_outs.pop_front();
            if (start_got !== want.start_res) begin
                flag_error($sformatf("result %0d start_res got %b want %b",
                                     out_count, start_got, want.start_res));
            end
            if (pressed_got !== want.pressed) begin
                flag_error($sformatf("result %0d pressed got %b want %b",
                                     out_count, pressed_got, want.pressed));
            end
        end
        out_count++;
    endtask

    // driver: one pin sample per transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_trigger(s_tdata[0]);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    s_tvalid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pin_queue.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {{(dtt_pkg::TDATA_W-1){1'b0}}, pin_queue.pop_front()};
                    gap_left <= pick_pause();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result transfer, stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(m_tdata[0], m_tdata[1]);
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_tready <= 1'b1;
                stall_left <= pick_pause();
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("debounced_trigger_two_four_stroke verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [dtt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dtt_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == dtt_pkg::CFG_DEBOUNCE_LIMIT) begin
            cfg_limit = val[dtt_pkg::LIMIT_W-1:0];
        end else begin
            cfg_mode = val[dtt_pkg::MODE_W-1:0];
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // hold until every queued sample has gone through and every result is back
    task automatic drain();
        while (pin_queue.size() > 0 || s_tvalid || pending_outs.size() > 0) begin
            @(negedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // queue n pin samples, bit 0 of the pattern first
    task automatic send(input logic [31:0] pattern, input int n);
        for (int i = 0; i < n; i++) begin
            pin_queue.push_back(pattern[i]);
        end
        drain();
    endtask

    initial begin
        int                          lim_draw;
        int                          lim_eff;
        int                          run_len;
        int                          n;
        logic                        lvl;
        logic [dtt_pkg::LIMIT_W-1:0] lim_val;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send(32'b00011, 5);
        write_reg(dtt_pkg::CFG_DEBOUNCE_LIMIT, '0);
        send(32'b0101, 4);
        write_reg(dtt_pkg::CFG_TRIGGER_MODE, dtt_pkg::CFG_DATA_W'(dtt_pkg::MODE_FOUR_STROKE));
        send(32'b0101, 4);
        write_reg(dtt_pkg::CFG_DEBOUNCE_LIMIT, 10'd5);
        send(32'b11111, 5);
        write_reg(dtt_pkg::CFG_DEBOUNCE_LIMIT, 10'd2);
        send(32'b001, 3);
        write_reg(dtt_pkg::CFG_DEBOUNCE_LIMIT, 10'd1023);
        write_reg(dtt_pkg::CFG_TRIGGER_MODE, dtt_pkg::CFG_DATA_W'(MODE_TWO_STROKE_ALT2));
        send(32'b11, 2);
        write_reg(dtt_pkg::CFG_TRIGGER_MODE, dtt_pkg::CFG_DATA_W'(MODE_TWO_STROKE_ALT3));
        send(32'b0, 1);

        for (int blk = 0; blk < 12; blk++) begin
            lim_draw = $urandom_range(0, 9);
            if (lim_draw == 0) begin
                lim_val = '0;
            end else if (lim_draw < 8) begin
                lim_val = dtt_pkg::LIMIT_W'($urandom_range(1, 8));
            end else begin
                lim_val = dtt_pkg::LIMIT_W'($urandom_range(9, 40));
            end
            lim_eff = (lim_val == '0) ? 1 : int'(lim_val);
            write_reg(dtt_pkg::CFG_DEBOUNCE_LIMIT, lim_val);
            write_reg(dtt_pkg::CFG_TRIGGER_MODE, dtt_pkg::CFG_DATA_W'($urandom_range(0, 3)));
            gaps_on = (blk % 4 != 3);

            n = 0;
            lvl = 1'b0;
            while (n < 100) begin
                if ($urandom_range(0, 4) == 0) begin
                    run_len = $urandom_range(1, lim_eff);
                end else begin
                    run_len = $urandom_range(lim_eff, 2 * lim_eff + 3);
                end
                for (int k = 0; k < run_len; k++) begin
                    pin_queue.push_back(($urandom_range(0, 19) == 0) ? !lvl : lvl);
                    n++;
                end
                lvl = !lvl;
            end
            drain();
        end

        gaps_on = 1'b1;
        repeat (8) @(posedge aclk);
        if (pending_outs.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", pending_outs.size()));
        end
        if (err_count == 0) begin
            $display("debounced_trigger_two_four_stroke verification clean");
        end else begin
            $display("debounced_trigger_two_four_stroke verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
